FILE: design/pole_pkg.sv
// Shared opcode and status codes for the positional ordered list engine.
package pole_pkg;

    localparam int ITEM_W = 32;
    localparam int POS_W  = 7;

    typedef logic [2:0] opcode_t;
    typedef logic [1:0] status_t;

    localparam opcode_t OP_INS_HEAD = 3'd0;
    localparam opcode_t OP_INS_POS  = 3'd1;
    localparam opcode_t OP_INS_TAIL = 3'd2;
    localparam opcode_t OP_DEL_HEAD = 3'd3;
    localparam opcode_t OP_DEL_POS  = 3'd4;
    localparam opcode_t OP_DEL_TAIL = 3'd5;
    localparam opcode_t OP_READ_ALL = 3'd6;

    localparam status_t ST_OK     = 2'd0;
    localparam status_t ST_EMPTY  = 2'd1;
    localparam status_t ST_BADPOS = 2'd2;
    localparam status_t ST_FULL   = 2'd3;

endpackage

FILE: design/positional_ordered_list_engine.sv
// Positional ordered list engine: list sequencer around a single entry memory.
//
// Holds up to CAPACITY values in one entry memory, head at address 0. One item is
// worked at a time; a new item is taken whenever the sequencer is idle, even while
// the previous result still waits in the output register. Status-only operations
// (tail delete, errors, full, empty) pass through accept, decode and report. An
// insert at one-based position p moves count-p+1 entries, one per cycle, then
// writes the new value, and a delete at p moves count-p entries, one per cycle;
// the single write port of the entry memory sets that pace. A read-out returns
// one entry per cycle and stalls with m_ready. No clearing pass runs after reset.
module positional_ordered_list_engine #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pole_pkg::opcode_t    s_opcode,
    input  logic signed [31:0]   s_item_value,
    input  logic [6:0]           s_position,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pole_pkg::status_t    m_status,
    output logic signed [31:0]   m_entry_value,
    output logic                 m_last
);

    import pole_pkg::*;

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNTW = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CNTW > POS_W) ? CNTW : POS_W) + 1;
    localparam int CW   = (VALUE_WIDTH < ITEM_W) ? VALUE_WIDTH : ITEM_W;
    localparam logic [CNTW-1:0] CAP_COUNT = CNTW'(CAPACITY);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_SHIFT_UP = 3'd2;
    localparam logic [2:0] S_SHIFT_DN = 3'd3;
    localparam logic [2:0] S_PLACE    = 3'd4;
    localparam logic [2:0] S_REPORT   = 3'd5;
    localparam logic [2:0] S_READ     = 3'd6;

    logic [2:0]             state_reg, state_next;
    logic [CNTW-1:0]        count_reg, count_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic [AW-1:0]          ptr_reg, ptr_next;
    status_t                status_reg, status_next;
    opcode_t                op_reg, op_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;

    logic                   m_valid_reg, m_valid_next;
    status_t                m_status_reg, m_status_next;
    logic [ITEM_W-1:0]      m_value_reg, m_value_next;
    logic                   m_last_reg, m_last_next;

    logic                   mem_we, mem_re;
    logic [AW-1:0]          mem_waddr, mem_raddr;
    logic [VALUE_WIDTH-1:0] mem_wdata, mem_rdata;

    logic [VALUE_WIDTH-1:0] item_wide;
    logic [ITEM_W-1:0]      rd_narrow;
    logic [CMPW-1:0]        pos_ext, cnt_ext, ins_idx_ext, del_idx_ext, del_nxt_ext;
    logic [CMPW-1:0]        ptr_p1_ext, ptr_p2_ext;
    logic [CNTW-1:0]        cnt_m1;
    logic                   full, empty, ins_bad, out_free, accept;

    pole_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .clk     (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign s_ready       = (state_reg == S_IDLE);
    assign accept        = s_valid && s_ready;
    assign out_free      = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_entry_value = m_value_reg;
    assign m_last        = m_last_reg;

    always_comb begin
        item_wide = '0;
        item_wide[CW-1:0] = s_item_value[CW-1:0];
        rd_narrow = '0;
        rd_narrow[CW-1:0] = mem_rdata[CW-1:0];
    end

    always_comb begin
        pos_ext     = CMPW'(pos_reg);
        cnt_ext     = CMPW'(count_reg);
        cnt_m1      = count_reg - CNTW'(1);
        full        = (count_reg == CAP_COUNT);
        empty       = (count_reg == '0);
        ins_bad     = (op_reg == OP_INS_POS) &&
                      ((pos_ext == '0) ||
                       ((pos_ext > CMPW'(1)) && (empty || (pos_ext > cnt_ext + CMPW'(1)))));
        ptr_p1_ext  = CMPW'(ptr_reg) + CMPW'(1);
        ptr_p2_ext  = CMPW'(ptr_reg) + CMPW'(2);
        ins_idx_ext = '0;
        del_idx_ext = '0;
        if (op_reg == OP_INS_POS || op_reg == OP_DEL_POS) begin
            ins_idx_ext = pos_ext - CMPW'(1);
            del_idx_ext = pos_ext - CMPW'(1);
        end else if (op_reg == OP_INS_TAIL) begin
            ins_idx_ext = cnt_ext;
        end
        del_nxt_ext = del_idx_ext + CMPW'(1);
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        ptr_next      = ptr_reg;
        status_next   = status_reg;
        op_next       = op_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_value_next  = m_value_reg;
        m_last_next   = m_last_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = mem_rdata;
        mem_re        = 1'b0;
        mem_raddr     = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next    = s_opcode;
                    pos_next   = s_position;
                    val_next   = item_wide;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next  = S_REPORT;
                status_next = ST_OK;
                unique case (op_reg)
                    OP_INS_HEAD, OP_INS_POS, OP_INS_TAIL: begin
                        if (ins_bad) begin
                            status_next = ST_BADPOS;
                        end else if (full) begin
                            status_next = ST_FULL;
                        end else begin
                            idx_next = ins_idx_ext[AW-1:0];
                            if (ins_idx_ext == cnt_ext) begin
                                state_next = S_PLACE;
                            end else begin
                                mem_re     = 1'b1;
                                mem_raddr  = cnt_m1[AW-1:0];
                                ptr_next   = count_reg[AW-1:0];
                                state_next = S_SHIFT_UP;
                            end
                        end
                    end
                    OP_DEL_HEAD, OP_DEL_POS: begin
                        if (empty) begin
                            status_next = ST_EMPTY;
                        end else if ((op_reg == OP_DEL_POS) &&
                                     ((pos_ext == '0) || (pos_ext > cnt_ext))) begin
                            status_next = ST_BADPOS;
                        end else if (del_nxt_ext == cnt_ext) begin
                            count_next = cnt_m1;
                        end else begin
                            mem_re     = 1'b1;
                            mem_raddr  = del_nxt_ext[AW-1:0];
                            ptr_next   = del_idx_ext[AW-1:0];
                            state_next = S_SHIFT_DN;
                        end
                    end
                    OP_DEL_TAIL: begin
                        if (empty) begin
                            status_next = ST_EMPTY;
                        end else begin
                            count_next = cnt_m1;
                        end
                    end
                    OP_READ_ALL: begin
                        if (empty) begin
                            status_next = ST_EMPTY;
                        end else begin
                            mem_re     = 1'b1;
                            mem_raddr  = '0;
                            ptr_next   = '0;
                            state_next = S_READ;
                        end
                    end
                    default: begin
                        status_next = ST_OK;
                    end
                endcase
            end
            S_SHIFT_UP: begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = mem_rdata;
                if ((ptr_reg - AW'(1)) == idx_reg) begin
                    state_next = S_PLACE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg - AW'(2);
                    ptr_next  = ptr_reg - AW'(1);
                end
            end
            S_SHIFT_DN: begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = mem_rdata;
                if (ptr_p2_ext < cnt_ext) begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_p2_ext[AW-1:0];
                    ptr_next  = ptr_p1_ext[AW-1:0];
                end else begin
                    count_next  = cnt_m1;
                    status_next = ST_OK;
                    state_next  = S_REPORT;
                end
            end
            S_PLACE: begin
                mem_we      = 1'b1;
                mem_waddr   = idx_reg;
                mem_wdata   = val_reg;
                count_next  = count_reg + CNTW'(1);
                status_next = ST_OK;
                state_next  = S_REPORT;
            end
            S_REPORT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_value_next  = '0;
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_READ: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = ST_OK;
                    m_value_next  = rd_narrow;
                    m_last_next   = (ptr_p1_ext == cnt_ext);
                    if (ptr_p1_ext == cnt_ext) begin
                        state_next = S_IDLE;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = ptr_p1_ext[AW-1:0];
                        ptr_next  = ptr_p1_ext[AW-1:0];
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        ptr_reg      <= ptr_next;
        status_reg   <= status_next;
        op_reg       <= op_next;
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        m_status_reg <= m_status_next;
        m_value_reg  <= m_value_next;
        m_last_reg   <= m_last_next;
    end

endmodule

FILE: design/pole_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module pole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                          clk,
    input  logic                                          wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
    input  logic [WIDTH-1:0]                              wr_data,
    input  logic                                          rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
    output logic [WIDTH-1:0]                              rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
